@@ rtl/core/ifd_pkg.sv @@
// Shared types and constants for the interleaved frame deframer.
`timescale 1ns / 1ps

package ifd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  localparam logic [ByteW-1:0] DollarByte = 8'h24;

  localparam int unsigned StreamCacheBytes = 20000;
  localparam int unsigned HeaderBytes      = 4;
  localparam logic [LenW-1:0] MaxLenReset  = LenW'(StreamCacheBytes - HeaderBytes);

  typedef enum logic [1:0] {
    StatusData   = 2'd0,
    StatusEmpty  = 2'd1,
    StatusReject = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] channel;
    logic [ByteW-1:0] data;
    logic             first;
    logic             last;
    status_e          status;
  } result_t;

endpackage

@@ rtl/core/ifd_in_stage.sv @@
// Input register holding one stream byte request.
`timescale 1ns / 1ps

module ifd_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ifd_pkg::ByteW-1:0] stream_byte_i,
  input  logic                    advance_i,
  output logic                    valid_o,
  output logic [ifd_pkg::ByteW-1:0] byte_o
);

  logic                      valid_q, valid_d;
  logic [ifd_pkg::ByteW-1:0] byte_q;
  logic                      load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= stream_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ rtl/core/ifd_parser.sv @@
// Frame header parser, payload counter and length limit register.
`timescale 1ns / 1ps

module ifd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ifd_pkg::LenW-1:0]    cfg_wdata_i,
  input  logic [ifd_pkg::ByteW-1:0]   byte_i,
  input  logic                        fire_i,
  output logic                        res_valid_o,
  output ifd_pkg::result_t            res_o
);

  typedef enum logic [2:0] {
    PhaseHunt    = 3'd0,
    PhaseChannel = 3'd1,
    PhaseLenHigh = 3'd2,
    PhaseLenLow  = 3'd3,
    PhasePayload = 3'd4
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [ifd_pkg::ByteW-1:0] channel_q, channel_d;
  logic [ifd_pkg::ByteW-1:0] len_high_q, len_high_d;
  logic [ifd_pkg::LenW-1:0]  remaining_q, remaining_d;
  logic                      first_q, first_d;
  logic [ifd_pkg::LenW-1:0]  max_len_q;
  logic [ifd_pkg::LenW-1:0]  frame_len;
  logic                      is_last;

  assign frame_len = {len_high_q, byte_i};
  assign is_last   = (remaining_q <= ifd_pkg::LenW'(1));

  always_comb begin
    phase_d     = phase_q;
    channel_d   = channel_q;
    len_high_d  = len_high_q;
    remaining_d = remaining_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '{channel: channel_q, data: '0, first: 1'b0, last: 1'b1,
                    status: ifd_pkg::StatusData};
    unique case (phase_q)
      PhaseChannel: begin
        channel_d = byte_i;
        phase_d   = PhaseLenHigh;
      end
      PhaseLenHigh: begin
        len_high_d = byte_i;
        phase_d    = PhaseLenLow;
      end
      PhaseLenLow: begin
        if (frame_len > max_len_q) begin
          res_valid_o  = 1'b1;
          res_o.status = ifd_pkg::StatusReject;
          phase_d      = PhaseHunt;
        end else if (frame_len == '0) begin
          res_valid_o  = 1'b1;
          res_o.status = ifd_pkg::StatusEmpty;
          phase_d      = PhaseHunt;
        end else begin
          remaining_d = frame_len;
          first_d     = 1'b1;
          phase_d     = PhasePayload;
        end
      end
      PhasePayload: begin
        res_valid_o = 1'b1;
        res_o.data  = byte_i;
        res_o.first = first_q;
        res_o.last  = is_last;
        first_d     = 1'b0;
        if (is_last) begin
          remaining_d = '0;
          phase_d     = PhaseHunt;
        end else begin
          remaining_d = remaining_q - ifd_pkg::LenW'(1);
        end
      end
      default: begin
        phase_d = (byte_i == ifd_pkg::DollarByte) ? PhaseChannel : PhaseHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhaseHunt;
      channel_q   <= '0;
      len_high_q  <= '0;
      remaining_q <= '0;
      first_q     <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      channel_q   <= channel_d;
      len_high_q  <= len_high_d;
      remaining_q <= remaining_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ifd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhasePayload |-> remaining_q != '0)
    else $error("payload phase with zero bytes remaining");

  a_header_to_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PhaseLenLow && !res_valid_o
    |=> phase_q == PhasePayload && first_q)
    else $error("accepted length did not start payload");

  a_last_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.last |=> phase_q == PhaseHunt)
    else $error("frame end did not return to hunting");

endmodule

@@ rtl/core/ifd_out_stage.sv @@
// Result register holding one deframed result request.
`timescale 1ns / 1ps

module ifd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ifd_pkg::result_t res_i,
  output logic             free_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output ifd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  ifd_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/interleaved_frame_deframer.sv @@
// A stream byte is held in the input register; its result is then captured in the result register.
// Throughput: one stream byte per cycle; the input register, parser and
// result register advance together whenever the result register is free
// or the held byte gives no result.
// Reset (rst_ni low, asynchronous): both registers empty, parser hunting
// for the dollar byte, length limit back to 19996.
`timescale 1ns / 1ps

module interleaved_frame_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ifd_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ifd_pkg::ByteW-1:0] stream_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ifd_pkg::ByteW-1:0] frame_channel_o,
  output logic [ifd_pkg::ByteW-1:0] payload_byte_o,
  output logic                      first_of_frame_o,
  output logic                      last_of_frame_o,
  output logic [1:0]                status_o
);

  logic                      stage_valid;
  logic [ifd_pkg::ByteW-1:0] stage_byte;
  logic                      advance;
  logic                      res_valid;
  ifd_pkg::result_t          res;
  logic                      out_free;
  ifd_pkg::result_t          out_res;

  assign advance = stage_valid && (!res_valid || out_free);

  ifd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .advance_i     (advance),
    .valid_o       (stage_valid),
    .byte_o        (stage_byte)
  );

  ifd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (stage_byte),
    .fire_i      (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ifd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign frame_channel_o  = out_res.channel;
  assign payload_byte_o   = out_res.data;
  assign first_of_frame_o = out_res.first;
  assign last_of_frame_o  = out_res.last;
  assign status_o         = out_res.status;

endmodule
